// File: rtl/lzss_pkg.sv
// lzss_pkg: shared types and constants for the lzss stream decompressor
// no dependencies
package lzss_pkg;

  localparam int unsigned WindowDepth    = 4096;
  localparam int unsigned BytesPerResult = 8;
  localparam int unsigned LenW           = 24;
  localparam int unsigned OutW           = 64;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StHeader = 2'd1;
  localparam logic [1:0] StRef    = 2'd2;
  localparam logic [1:0] StTrunc  = 2'd3;

  localparam logic [7:0] FlagMsb  = 8'h80;
  localparam logic [8:0] ExtBias  = 9'd17;
  localparam logic [3:0] NibMask  = 4'd15;
  localparam int unsigned RefNib  = 16;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [OutW-1:0] out_bytes;
    logic [3:0]      byte_count;
    logic            stream_end;
    logic [1:0]      status;
  } out_item_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       start;       // new stream: clear counters, begin window clear
    logic       len_shift;   // shift byte into expected length
    logic       load_flags;
    logic       next_bit;
    logic       load_a;
    logic       load_b;
    logic       copy_start;  // begin a copy of the decoded length
    logic       ext_len;     // copy length from extension byte
    logic       literal;     // write a literal byte
    logic       emit_status;
    logic [1:0] status;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic       busy;        // copy or clear running or output pending
    logic       next_flag;   // flag of the bit after the current one
    logic       bit_wrap;    // bit position is 7
    logic       done_len;    // produced equals expected
    logic       len_zero;
    logic       nib_zero;
    logic       ref_bad;     // distance zero or length beyond remaining
    logic       ext_bad;
  } stat_t;

endpackage

// File: rtl/lzss_if.sv
// lzss_if: valid/ready channel carrying one item
// depends on nothing
interface lzss_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/lzss_ram.sv
// lzss_ram: generic single-port ram with registered read
// no dependencies
module lzss_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write, or registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: rtl/lzss_dp.sv
// lzss_dp: datapath with counters, window ram, copy engine and output packer
// depends on lzss_pkg, lzss_ram
module lzss_dp #(
  parameter int unsigned WindowDepth    = lzss_pkg::WindowDepth,
  parameter int unsigned BytesPerResult = lzss_pkg::BytesPerResult
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          byte_i,
  input  lzss_pkg::cmd_t      cmd_i,
  output lzss_pkg::stat_t     stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lzss_pkg::out_item_t out_data_o
);
  import lzss_pkg::*;

  localparam int unsigned AW = $clog2(WindowDepth);
  localparam int unsigned CW = $clog2(BytesPerResult + 1);

  typedef enum logic [3:0] {
    CpIdle = 4'b0001, CpRead = 4'b0010, CpWrite = 4'b0100, CpClear = 4'b1000
  } cp_e;

  cp_e             cp_q, cp_d;
  logic [LenW-1:0] exp_q, prod_q;
  logic [7:0]      flags_q, tok_a_q, tok_b_q;
  logic [2:0]      bit_q;
  logic [8:0]      rem_q;       // bytes left in current copy
  logic [11:0]     dist_q;
  logic [AW:0]     clr_q;
  logic [OutW-1:0] pack_q;
  logic [CW-1:0]   cnt_q;
  logic            ov_q;
  out_item_t       od_q;
  logic            we;
  logic [AW-1:0]   addr;
  logic [7:0]      wdata, rdata;
  logic [11:0]     dist_new;
  logic [8:0]      len_new;
  logic [LenW-1:0] left;
  logic            zero_rd;
  logic [7:0]      cp_byte;
  logic            rd_zero_q;
  logic            pack_full, out_free;

  assign dist_new = {tok_a_q[7:4], byte_i};
  assign left     = exp_q - prod_q;
  assign len_new  = cmd_i.ext_len ? ({1'b0, byte_i} + ExtBias)
                                  : {5'd0, (tok_a_q[3:0] & NibMask)} + 9'd1;
  assign out_free = !ov_q || out_ready_i;

  // window ram
  lzss_ram #(.Width(8), .Depth(WindowDepth)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  assign zero_rd = {12'd0, dist_q} > prod_q;
  assign cp_byte = rd_zero_q ? 8'd0 : rdata;
  assign pack_full = (cnt_q == CW'(BytesPerResult));

  // ram port control
  always_comb begin
    we = 1'b0; addr = prod_q[AW-1:0]; wdata = byte_i;
    case (cp_q)
      CpClear: begin we = 1'b1; addr = clr_q[AW-1:0]; wdata = 8'd0; end
      CpRead:  addr = AW'(prod_q - {12'd0, dist_q});
      CpWrite: begin we = !pack_full || out_free; wdata = cp_byte; end
      default: begin we = cmd_i.literal; end
    endcase
  end

  // copy sequencer
  always_comb begin
    cp_d = cp_q;
    case (cp_q)
      CpIdle:  if (cmd_i.start) cp_d = CpClear;
               else if (cmd_i.copy_start) cp_d = CpRead;
      CpClear: if (clr_q == (AW+1)'(WindowDepth - 1)) cp_d = CpIdle;
      CpRead:  cp_d = CpWrite;
      CpWrite: if (we) cp_d = (rem_q == 9'd1) ? CpIdle : CpRead;
      default: cp_d = CpIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_q <= CpIdle; exp_q <= '0; prod_q <= '0; flags_q <= '0; bit_q <= '0;
      tok_a_q <= '0; tok_b_q <= '0; rem_q <= '0; dist_q <= '0; clr_q <= '0;
      cnt_q <= '0; pack_q <= '0; ov_q <= 1'b0; rd_zero_q <= 1'b0; od_q <= '0;
    end else begin
      cp_q <= cp_d;
      if (out_ready_i) ov_q <= 1'b0;
      if (cmd_i.start) begin
        prod_q <= '0; exp_q <= '0; bit_q <= '0; flags_q <= '0;
        tok_a_q <= '0; tok_b_q <= '0; clr_q <= '0;
      end
      if (cp_q == CpClear) clr_q <= clr_q + 1'b1;
      if (cmd_i.len_shift) exp_q <= {exp_q[LenW-9:0], byte_i};
      if (cmd_i.load_flags) begin flags_q <= byte_i; bit_q <= '0; end
      if (cmd_i.next_bit) bit_q <= bit_q + 3'd1;
      if (cmd_i.load_a) tok_a_q <= byte_i;
      if (cmd_i.load_b) begin tok_b_q <= byte_i; dist_q <= dist_new; end
      if (cmd_i.copy_start) rem_q <= len_new;
      if (cp_q == CpRead) rd_zero_q <= zero_rd;
      // literal goes out alone
      if (cmd_i.literal) begin
        prod_q <= prod_q + 1'b1;
        ov_q <= 1'b1;
        od_q <= '{out_bytes: {56'd0, byte_i}, byte_count: 4'd1,
                  stream_end: 1'b0, status: StOk};
      end
      // copy byte into the packer, flushing when full; a partial packer flushes once idle
      if (cp_q == CpWrite && we) begin
        logic [CW-1:0] nc;
        logic [OutW-1:0] np;
        nc = pack_full ? CW'(1) : cnt_q + 1'b1;
        np = pack_full ? {56'd0, cp_byte}
                       : pack_q | ({56'd0, cp_byte} << (8 * cnt_q));
        if (pack_full) begin
          ov_q <= 1'b1;
          od_q <= '{out_bytes: pack_q, byte_count: 4'(cnt_q),
                    stream_end: 1'b0, status: StOk};
        end
        prod_q <= prod_q + 1'b1;
        rem_q <= rem_q - 9'd1;
        cnt_q <= nc; pack_q <= np;
      end
      if (cp_q == CpIdle && cnt_q != '0 && out_free) begin
        ov_q <= 1'b1; cnt_q <= '0; pack_q <= '0;
        od_q <= '{out_bytes: pack_q, byte_count: 4'(cnt_q),
                  stream_end: 1'b0, status: StOk};
      end
      if (cmd_i.emit_status) begin
        ov_q <= 1'b1;
        od_q <= '{out_bytes: '0, byte_count: 4'd0, stream_end: 1'b1,
                  status: cmd_i.status};
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  // status toward the controller
  always_comb begin
    stat_o.busy      = (cp_q != CpIdle) || cnt_q != '0 || (ov_q && !out_ready_i);
    stat_o.next_flag = |(flags_q & (FlagMsb >> (bit_q + 3'd1)));
    stat_o.bit_wrap  = (bit_q == 3'd7);
    stat_o.done_len  = (prod_q == exp_q);
    stat_o.len_zero  = ({exp_q[LenW-9:0], byte_i} == '0);
    stat_o.nib_zero  = (tok_a_q[3:0] == 4'd0);
    stat_o.ref_bad   = (dist_new == '0) || ({15'd0, len_new} > left);
    stat_o.ext_bad   = (tok_b_q == 8'd0 && tok_a_q[7:4] == 4'd0) ||
                       ({15'd0, len_new} > left);
  end
endmodule

// File: rtl/lzss_ctrl.sv
// lzss_ctrl: phase state machine sequencing header, flags and tokens
// depends on lzss_pkg
module lzss_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lzss_pkg::in_item_t  in_data_i,
  input  lzss_pkg::stat_t     stat_i,
  output lzss_pkg::cmd_t      cmd_o
);
  import lzss_pkg::*;

  typedef enum logic [10:0] {
    PhVersion = 11'b00000000001, PhLenHi = 11'b00000000010,
    PhLenMid = 11'b00000000100, PhLenLo = 11'b00000001000,
    PhFlags = 11'b00000010000, PhLiteral = 11'b00000100000,
    PhRefA = 11'b00001000000, PhRefB = 11'b00010000000,
    PhRefExt = 11'b00100000000, PhDrain = 11'b01000000000,
    PhAfter = 11'b10000000000
  } ph_e;

  ph_e  ph_q, ph_d;
  logic last_q, last_d;
  logic acc;
  logic [7:0] b;
  logic lst;

  assign b   = in_data_i.byte_in;
  assign lst = in_data_i.last_in;
  assign in_ready_o = !stat_i.busy && ph_q != PhAfter;
  assign acc = in_valid_i && in_ready_o;

  // phase decode
  always_comb begin
    ph_d = ph_q; last_d = last_q; cmd_o = '0;
    case (ph_q)
      PhAfter: if (!stat_i.busy) begin
        // token finished: check completion, truncation, next bit
        if (stat_i.done_len) begin
          cmd_o.emit_status = 1'b1; cmd_o.status = StOk;
          ph_d = last_q ? PhVersion : PhDrain;
        end else if (last_q) begin
          cmd_o.emit_status = 1'b1; cmd_o.status = StTrunc; ph_d = PhVersion;
        end else begin
          // next_flag already looks at the following bit
          cmd_o.next_bit = 1'b1;
          ph_d = stat_i.bit_wrap ? PhFlags : (stat_i.next_flag ? PhRefA : PhLiteral);
        end
      end
      default: if (acc) begin
        case (ph_q)
          PhVersion: begin
            cmd_o.start = 1'b1;
            if ((b != 8'd1 && b != 8'd2) || lst) begin
              cmd_o.emit_status = 1'b1; cmd_o.status = StHeader;
              ph_d = lst ? PhVersion : PhDrain;
            end else ph_d = PhLenHi;
          end
          PhLenHi, PhLenMid: begin
            cmd_o.len_shift = 1'b1;
            if (lst) begin
              cmd_o.emit_status = 1'b1; cmd_o.status = StHeader; ph_d = PhVersion;
            end else ph_d = (ph_q == PhLenHi) ? PhLenMid : PhLenLo;
          end
          PhLenLo: begin
            cmd_o.len_shift = 1'b1;
            if (lst) begin
              cmd_o.emit_status = 1'b1; cmd_o.status = StHeader; ph_d = PhVersion;
            end else if (stat_i.len_zero) begin
              cmd_o.emit_status = 1'b1; cmd_o.status = StOk; ph_d = PhDrain;
            end else ph_d = PhFlags;
          end
          PhFlags: begin
            cmd_o.load_flags = 1'b1;
            if (lst) begin
              cmd_o.emit_status = 1'b1; cmd_o.status = StTrunc; ph_d = PhVersion;
            end else ph_d = b[7] ? PhRefA : PhLiteral;
          end
          PhLiteral: begin
            cmd_o.literal = 1'b1; last_d = lst; ph_d = PhAfter;
          end
          PhRefA: begin
            cmd_o.load_a = 1'b1;
            if (lst) begin
              cmd_o.emit_status = 1'b1; cmd_o.status = StTrunc; ph_d = PhVersion;
            end else ph_d = PhRefB;
          end
          PhRefB: begin
            cmd_o.load_b = 1'b1;
            if (!stat_i.nib_zero) begin
              if (stat_i.ref_bad) begin
                cmd_o.emit_status = 1'b1; cmd_o.status = StRef;
                ph_d = lst ? PhVersion : PhDrain;
              end else begin
                cmd_o.copy_start = 1'b1; last_d = lst; ph_d = PhAfter;
              end
            end else if (lst) begin
              cmd_o.emit_status = 1'b1; cmd_o.status = StTrunc; ph_d = PhVersion;
            end else ph_d = PhRefExt;
          end
          PhRefExt: begin
            cmd_o.ext_len = 1'b1;
            if (stat_i.ext_bad) begin
              cmd_o.emit_status = 1'b1; cmd_o.status = StRef;
              ph_d = lst ? PhVersion : PhDrain;
            end else begin
              cmd_o.copy_start = 1'b1; last_d = lst; ph_d = PhAfter;
            end
          end
          default: if (lst) ph_d = PhVersion;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhVersion; last_q <= 1'b0;
    end else begin
      ph_q <= ph_d; last_q <= last_d;
    end
  end
endmodule

// File: rtl/lzss_stream_decompressor_top.sv
// lzss_stream_decompressor_top: lzss decoder with a 4096-byte window
// depends on lzss_pkg, lzss_if, lzss_ctrl, lzss_dp, lzss_ram
//
// usage: in_if carries one compressed byte per item plus a last marker;
// out_if carries results of up to eight decoded bytes, or one status item
// that ends the stream. a literal is accepted, then checked for completion,
// and its result is in the output register in the cycle after the accept.
// a reference is accepted, then each copied byte is read and then written
// through the single window ram port; the last partial result is flushed
// and a completion check follows before the next item is taken.
// each version byte starts a clear of the whole window, during which no item
// is taken. after reset the block waits for a version byte.
// one output register holds a result; while the receiver stalls, copies
// pause on a full packer and no new item is taken.
module lzss_stream_decompressor_top #(
  parameter int unsigned WindowDepth    = lzss_pkg::WindowDepth,
  parameter int unsigned BytesPerResult = lzss_pkg::BytesPerResult
) (
  input logic clk_i,
  input logic rst_ni,
  lzss_if.sink   in_if,
  lzss_if.source out_if
);
  import lzss_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // phase controller
  lzss_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .in_data_i(in_if.data), .stat_i(stat), .cmd_o(cmd)
  );

  // datapath
  lzss_dp #(.WindowDepth(WindowDepth), .BytesPerResult(BytesPerResult)) u_dp (
    .clk_i, .rst_ni, .byte_i(in_if.data.byte_in), .cmd_i(cmd), .stat_o(stat),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .out_data_o(out_if.data)
  );
endmodule

// File: rtl/lzss_chk.sv
// lzss_chk: port-level checker bound to the top level
// depends on lzss_pkg
module lzss_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid,
  input logic out_ready,
  input lzss_pkg::out_item_t out_data
);
  import lzss_pkg::*;

  // a waiting result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("hold");
  // byte count stays in range
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.byte_count <= 4'd8) else $error("count");
  // status results carry no bytes
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.stream_end |-> out_data.byte_count == 4'd0)
    else $error("end");
  // data results report ok
  a_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data.stream_end |-> out_data.status == StOk &&
    out_data.byte_count != 4'd0) else $error("ok");
endmodule

bind lzss_stream_decompressor_top lzss_chk u_chk (
  .clk_i, .rst_ni, .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_data(out_if.data)
);

// File: tb/sv/lzss_stream_checker.sv
// lzss_stream_checker: watches both channels of the lzss decompressor,
// predicts every result from the accepted input items and compares them
// depends on lzss_pkg
module lzss_stream_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  lzss_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  lzss_pkg::out_item_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  results_o,
  output int                  streams_o
);
  import lzss_pkg::*;

  typedef enum logic [3:0] {
    PhVersion, PhLenHi, PhLenMid, PhLenLo, PhFlags,
    PhLiteral, PhRefA, PhRefB, PhRefExt, PhDrain
  } dec_phase_e;

  dec_phase_e  phase;
  logic [7:0]  flag_bits;
  logic [2:0]  bit_pos;
  logic [23:0] owed_len;
  logic [23:0] made_cnt;
  logic [7:0]  ref_hi;
  logic [7:0]  ref_lo;
  logic [7:0]  window [WindowDepth];
  logic [63:0] pack_val;
  int          pack_cnt;

  out_item_t   expected_q [$];

  assign pending_o = expected_q.size();

  // push the partial chunk, if any
  task automatic flush_pack();
    out_item_t r;
    if (pack_cnt != 0) begin
      r.out_bytes  = pack_val;
      r.byte_count = 4'(pack_cnt);
      r.stream_end = 1'b0;
      r.status     = StOk;
      expected_q.push_back(r);
    end
    pack_val = '0;
    pack_cnt = 0;
  endtask

  task automatic put_byte(input logic [7:0] b);
    window[made_cnt[11:0]] = b;
    made_cnt = made_cnt + 24'd1;
    pack_val[8*pack_cnt +: 8] = b;
    pack_cnt++;
    if (pack_cnt >= BytesPerResult) flush_pack();
  endtask

  task automatic end_stream(input logic [1:0] st, input logic last);
    out_item_t r;
    flush_pack();
    r.out_bytes  = '0;
    r.byte_count = 4'd0;
    r.stream_end = 1'b1;
    r.status     = st;
    expected_q.push_back(r);
    streams_o++;
    phase = last ? PhVersion : PhDrain;
  endtask

  task automatic pick_token();
    phase = (flag_bits & (FlagMsb >> bit_pos)) != 0 ? PhRefA : PhLiteral;
  endtask

  task automatic token_done(input logic last);
    if (made_cnt == owed_len) begin
      end_stream(StOk, last);
    end else if (last) begin
      end_stream(StTrunc, 1'b1);
    end else begin
      bit_pos = bit_pos + 3'd1;
      if (bit_pos == 3'd0) phase = PhFlags;
      else pick_token();
    end
  endtask

  task automatic copy_ref(input int len, input logic last);
    logic [11:0] ref_dist;
    logic [23:0] back;
    int          left;
    logic [7:0]  v;
    ref_dist = {ref_hi[7:4], ref_lo};
    left = int'(owed_len - made_cnt);
    if (ref_dist == 12'd0 || len > left) begin
      end_stream(StRef, last);
    end else begin
      for (int i = 0; i < len; i++) begin
        v = 8'h00;
        back = made_cnt - 24'(ref_dist);
        if (24'(ref_dist) <= made_cnt) v = window[back[11:0]];
        put_byte(v);
      end
      flush_pack();
      token_done(last);
    end
  endtask

  // one compressed byte through the decoder
  task automatic decode_item(input logic [7:0] b, input logic last);
    pack_val = '0;
    pack_cnt = 0;
    case (phase)
      PhVersion: begin
        for (int i = 0; i < WindowDepth; i++) window[i] = 8'h00;
        made_cnt  = '0;
        owed_len  = '0;
        flag_bits = '0;
        bit_pos   = '0;
        ref_hi    = '0;
        ref_lo    = '0;
        if ((b != 8'd1 && b != 8'd2) || last) end_stream(StHeader, last);
        else phase = PhLenHi;
      end
      PhLenHi, PhLenMid: begin
        owed_len = {owed_len[15:0], b};
        if (last) end_stream(StHeader, 1'b1);
        else phase = (phase == PhLenHi) ? PhLenMid : PhLenLo;
      end
      PhLenLo: begin
        owed_len = {owed_len[15:0], b};
        if (last) end_stream(StHeader, 1'b1);
        else if (owed_len == 24'd0) end_stream(StOk, 1'b0);
        else begin
          bit_pos = '0;
          phase   = PhFlags;
        end
      end
      PhFlags: begin
        flag_bits = b;
        bit_pos   = '0;
        if (last) end_stream(StTrunc, 1'b1);
        else pick_token();
      end
      PhLiteral: begin
        put_byte(b);
        flush_pack();
        token_done(last);
      end
      PhRefA: begin
        ref_hi = b;
        if (last) end_stream(StTrunc, 1'b1);
        else phase = PhRefB;
      end
      PhRefB: begin
        ref_lo = b;
        if ((ref_hi & NibMask) != 0) copy_ref(int'(ref_hi[3:0]) + 1, last);
        else if (last) end_stream(StTrunc, 1'b1);
        else phase = PhRefExt;
      end
      PhRefExt: copy_ref(int'(b) + int'(ExtBias), last);
      default: if (last) phase = PhVersion;
    endcase
  endtask

  initial begin
    phase        = PhVersion;
    flag_bits    = '0;
    bit_pos      = '0;
    owed_len     = '0;
    made_cnt     = '0;
    ref_hi       = '0;
    ref_lo       = '0;
    pack_val     = '0;
    pack_cnt     = 0;
    fail_count_o = 0;
    results_o    = 0;
    streams_o    = 0;
    for (int i = 0; i < WindowDepth; i++) window[i] = 8'h00;
  end

  // compare accepted results, then predict from the accepted input item
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result bytes=%h count=%0d end=%0b status=%0d",
                   $time, out_data_i.out_bytes, out_data_i.byte_count,
                   out_data_i.stream_end, out_data_i.status);
          fail_count_o++;
        end else begin
          e = expected_q.pop_front();
          if (out_data_i.out_bytes !== e.out_bytes ||
              out_data_i.byte_count !== e.byte_count ||
              out_data_i.stream_end !== e.stream_end ||
              out_data_i.status !== e.status) begin
            $display("%0t: mismatch expected bytes=%h count=%0d end=%0b status=%0d",
                     $time, e.out_bytes, e.byte_count, e.stream_end, e.status);
            $display("%0t:          actual   bytes=%h count=%0d end=%0b status=%0d",
                     $time, out_data_i.out_bytes, out_data_i.byte_count,
                     out_data_i.stream_end, out_data_i.status);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) decode_item(in_data_i.byte_in, in_data_i.last_in);
    end
  end

endmodule

// File: tb/sv/lzss_stream_decompressor_top_test.sv
// lzss_stream_decompressor_top_test: stimulus, handshakes and verdict
// depends on lzss_pkg, lzss_if, lzss_stream_decompressor_top, lzss_stream_checker
module lzss_stream_decompressor_top_test;
  import lzss_pkg::*;

  localparam int IdleLimit = 20000;
  localparam int LongHold  = 600;

  logic clk_i;
  logic rst_ni;

  lzss_if #(.T(in_item_t))  in_ch ();
  lzss_if #(.T(out_item_t)) out_ch ();

  int fail_count;
  int pending;
  int results;
  int streams;
  int idle_cycles;
  int sent;
  int hold_req;
  int hold_seen;

  in_item_t stim_q [$];

  lzss_stream_decompressor_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  lzss_stream_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_data_i    (in_ch.data),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_data_i   (out_ch.data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .streams_o    (streams)
  );

  // clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  task automatic add_item(input logic [7:0] b, input logic l);
    in_item_t it;
    it.byte_in = b;
    it.last_in = l;
    stim_q.push_back(it);
  endtask

  // well-formed stream with random content, sometimes cut short or corrupted
  task automatic add_stream();
    in_item_t s [$];
    in_item_t it;
    int owed;
    int made;
    int len;
    int ref_dist;
    int room;
    logic [7:0] flags;
    owed = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 700) : $urandom_range(1, 60);
    made = 0;
    it.last_in = 1'b0;
    it.byte_in = 8'($urandom_range(1, 2)); s.push_back(it);
    it.byte_in = 8'(owed >> 16); s.push_back(it);
    it.byte_in = 8'(owed >> 8);  s.push_back(it);
    it.byte_in = 8'(owed);       s.push_back(it);
    while (made < owed) begin
      flags = 8'($urandom);
      it.byte_in = flags;
      s.push_back(it);
      for (int i = 7; i >= 0 && made < owed; i--) begin
        if (flags[i] && owed - made < 2) begin
          // no reference fits: use a literal instead
          flags[i] = 1'b0;
        end
        if (!flags[i]) begin
          it.byte_in = 8'($urandom);
          s.push_back(it);
          made++;
        end else begin
          room = owed - made;
          if (room > 272) room = 272;
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(2, room)
                                            : $urandom_range(2, (room < 16) ? room : 16);
          ref_dist = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4095)
                                                 : $urandom_range(1, made + 2);
          it.byte_in = {4'(ref_dist >> 8), (len <= 16) ? 4'(len - 1) : 4'd0};
          s.push_back(it);
          it.byte_in = 8'(ref_dist);
          s.push_back(it);
          if (len > 16) begin
            it.byte_in = 8'(len - 17);
            s.push_back(it);
          end
          made += len;
        end
      end
    end
    // broken variants
    case ($urandom_range(0, 7))
      0: s = s[0:$urandom_range(0, s.size() - 1)];
      1: s[$urandom_range(0, s.size() - 1)].byte_in = 8'($urandom);
      default: ;
    endcase
    s[s.size() - 1].last_in = 1'b1;
    foreach (s[i]) stim_q.push_back(s[i]);
  endtask

  // directed cases
  task automatic add_directed();
    add_item(8'h01, 1'b1);                         // header cut at version
    add_item(8'hFF, 1'b0); add_item(8'hAA, 1'b1);  // bad version, drained
    add_item(8'h02, 1'b0); add_item(8'h00, 1'b0);  // empty output
    add_item(8'h00, 1'b0); add_item(8'h00, 1'b0); add_item(8'h55, 1'b1);
    // literal ff, then a reference reaching before the start
    add_item(8'h01, 1'b0); add_item(8'h00, 1'b0); add_item(8'h00, 1'b0);
    add_item(8'h03, 1'b0); add_item(8'h40, 1'b0); add_item(8'hFF, 1'b0);
    add_item(8'hF1, 1'b0); add_item(8'hFF, 1'b1);
    // zero distance
    add_item(8'h02, 1'b0); add_item(8'h00, 1'b0); add_item(8'h00, 1'b0);
    add_item(8'h05, 1'b0); add_item(8'h80, 1'b0); add_item(8'h01, 1'b0);
    add_item(8'h00, 1'b1);
    // overrun of the owed length
    add_item(8'h01, 1'b0); add_item(8'h00, 1'b0); add_item(8'h00, 1'b0);
    add_item(8'h02, 1'b0); add_item(8'h80, 1'b0); add_item(8'h02, 1'b0);
    add_item(8'h01, 1'b1);
    // longest extended copy
    add_item(8'h01, 1'b0); add_item(8'h00, 1'b0); add_item(8'h01, 1'b0);
    add_item(8'h10, 1'b0); add_item(8'h80, 1'b0); add_item(8'h00, 1'b0);
    add_item(8'h01, 1'b0); add_item(8'hFF, 1'b1);
  endtask

  // watchdog on cycles with no accepted item
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no progress for %0d cycles", $time, IdleLimit);
      $display("lzss_stream_decompressor_top_test failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_seen = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        out_ch.ready = 1'b0;
        repeat (LongHold) @(negedge clk_i);
      end
      if ($urandom_range(0, 3) != 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // sender and verdict
  initial begin
    in_item_t it;
    int gap;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    rst_ni      = 1'b0;
    idle_cycles = 0;
    sent        = 0;
    hold_req    = 0;
    add_directed();
    while (stim_q.size() < 450) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 6)) add_item(8'($urandom), ($urandom_range(0, 7) == 0));
      end else begin
        add_stream();
      end
    end
    // keep the run near 450 items when the last stream was long
    while (stim_q.size() > 470) void'(stim_q.pop_back());
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    while (stim_q.size() != 0) begin
      it = stim_q.pop_front();
      if (sent == 150) hold_req++;
      if (sent == 300) begin
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      // bursts without gaps now and then
      gap = ((sent / 40) % 3 == 2) ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_ch.valid = 1'b1;
      in_ch.data  = it;
      do @(posedge clk_i); while (!in_ch.ready);
      sent++;
      @(negedge clk_i);
    end
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
    $display("sent %0d compressed bytes, checked %0d results over %0d ended streams",
             sent, results, streams);
    $display("covered header errors, empty and truncated streams, bad references, long copies");
    if (fail_count == 0 && pending == 0) begin
      $display("lzss_stream_decompressor_top_test passed");
    end else begin
      $display("%0d failures, %0d results never came", fail_count, pending);
      $display("lzss_stream_decompressor_top_test failed");
    end
    $finish;
  end

endmodule
